### rtl/wks_pkg.sv
// Package for the weighted keyword scan: sizes, item modes and sequencer states.
// Used by weighted_keyword_scan and the testbench.
package wks_pkg;
   localparam int NumTerms   = 32;
   localparam int MaxTermLen = 16;
   localparam int TermW      = 5;
   localparam int PosW       = 4;
   localparam int LenW       = 5;
   localparam int CharAddrW  = TermW + PosW;
   localparam int CountW     = 16;
   localparam int PointsW    = 20;
   localparam int ScoreW     = 24;
   localparam logic [CountW-1:0] CountMax = '1;
   localparam logic [ScoreW-1:0] ScoreMax = '1;

   typedef enum logic [2:0] {
      MODE_LOAD_CHAR = 3'd0,
      MODE_SET_TERM  = 3'd1,
      MODE_SCAN      = 3'd2,
      MODE_EOL       = 3'd3,
      MODE_REPORT    = 3'd4
   } mode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN_RD,
      ST_SCAN_CMP,
      ST_REP_RD,
      ST_REP_MUL,
      ST_REP_OUT,
      ST_TOT_OUT
   } state_type;
endpackage

### rtl/weighted_keyword_scan.sv
// Weighted keyword scan top level: term table memory, per-term counters, sequencer.
// Depends on wks_pkg and wks_ram.
//
//   channel | direction | ports
//   req_    | in        | req_valid/req_ready, mode, term_index, char_pos, byte_value, ...
//   rsp_    | out       | rsp_valid/rsp_ready, out_term, hit_count, term_points, ...
//
// A scanned byte is accepted, the row of term 0 is read, then each term is compared
// in turn; the character RAM holds one 16-byte term per row.
// A report reads each term and skips those without hits; a term with hits is read,
// multiplied and output, then the total item follows; each result waits on rsp_ready.
// Char loads are a row read-modify-write; other loads, end of line and unused modes
// take effect on accept. Reset clears lengths, weights, window, counts and score;
// the character RAM is not cleared.
module weighted_keyword_scan
   import wks_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [2:0]         req_mode,
   input  logic [TermW-1:0]   req_term_index,
   input  logic [PosW-1:0]    req_char_pos,
   input  logic [7:0]         req_byte_value,
   input  logic [LenW-1:0]    req_term_length,
   input  logic [3:0]         req_point_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [TermW-1:0]   rsp_out_term,
   output logic [CountW-1:0]  rsp_hit_count,
   output logic [PointsW-1:0] rsp_term_points,
   output logic [ScoreW-1:0]  rsp_total_score,
   output logic               rsp_is_total,
   output logic               rsp_last
);
   localparam int RowW = 8 * MaxTermLen;

   state_type state_ff, state_in;
   logic [TermW-1:0] t_ff, t_in;
   logic [LenW-1:0] len_ff [NumTerms];
   logic [3:0] wt_ff [NumTerms];
   logic [LenW-1:0] since_ff [NumTerms];
   logic [CountW-1:0] cnt_ff [NumTerms];
   logic [7:0] recent_ff [MaxTermLen];
   logic [ScoreW-1:0] score_ff;
   logic [PointsW-1:0] pts_ff;
   logic [7:0] folded;

   // term characters: one row per term, byte lanes written by read-modify-write
   logic ram_we;
   logic [TermW-1:0] ram_waddr, ram_raddr;
   logic [RowW-1:0] ram_wdata, ram_rdata;
   logic [PosW-1:0] ld_pos_ff;
   logic [7:0] ld_byte_ff;
   logic [TermW-1:0] ld_term_ff;
   logic ld_pend_ff;

   wks_ram #(.Width(RowW), .Depth(NumTerms)) u_chars (
      .clock(clock), .wr_en(ram_we), .wr_addr(ram_waddr), .wr_data(ram_wdata),
      .rd_addr(ram_raddr), .rd_data(ram_rdata));

   logic accept;
   assign req_ready = (state_ff == ST_IDLE) && !ld_pend_ff && !rsp_valid;
   assign accept = req_valid && req_ready;

   always_comb begin
      folded = req_byte_value;
      if (req_byte_value >= 8'h41 && req_byte_value <= 8'h5A) folded = req_byte_value + 8'd32;
   end

   always_comb begin
      ram_we = ld_pend_ff;
      ram_waddr = ld_term_ff;
      ram_wdata = ram_rdata;
      ram_wdata[ld_pos_ff*8 +: 8] = ld_byte_ff;
      ram_raddr = t_ff;
      if (accept) ram_raddr = req_term_index;
      else if (state_ff == ST_SCAN_CMP) ram_raddr = t_ff + TermW'(1);
   end

   // match for term t_ff against the window
   logic [LenW-1:0] cur_len, since_inc;
   logic match;
   always_comb begin
      cur_len = len_ff[t_ff];
      since_inc = since_ff[t_ff];
      if (since_inc < LenW'(MaxTermLen)) since_inc = since_inc + LenW'(1);
      match = (cur_len != '0) && (since_inc >= cur_len);
      for (int p = 0; p < MaxTermLen; p++) begin
         if (LenW'(p) < cur_len &&
             ram_rdata[p*8 +: 8] != recent_ff[PosW'(cur_len - LenW'(1) - LenW'(p))])
            match = 1'b0;
      end
   end

   logic [ScoreW:0] score_add;
   assign score_add = {1'b0, score_ff} + (ScoreW+1)'(wt_ff[t_ff]);

   always_comb begin
      state_in = state_ff;
      t_in = t_ff;
      case (state_ff)
         ST_IDLE: begin
            t_in = '0;
            if (accept && req_mode == MODE_SCAN) state_in = ST_SCAN_RD;
            if (accept && req_mode == MODE_REPORT) state_in = ST_REP_RD;
         end
         ST_SCAN_RD:  state_in = ST_SCAN_CMP;
         ST_SCAN_CMP: begin
            t_in = t_ff + TermW'(1);
            state_in = (t_ff == TermW'(NumTerms-1)) ? ST_IDLE : ST_SCAN_CMP;
         end
         ST_REP_RD: state_in = (cnt_ff[t_ff] != '0) ? ST_REP_MUL
                             : (t_ff == TermW'(NumTerms-1)) ? ST_TOT_OUT : ST_REP_RD;
         ST_REP_MUL: state_in = ST_REP_OUT;
         ST_REP_OUT: if (rsp_ready) state_in =
                        (t_ff == TermW'(NumTerms-1)) ? ST_TOT_OUT : ST_REP_RD;
         ST_TOT_OUT: if (rsp_ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
      if (state_ff == ST_REP_RD && cnt_ff[t_ff] == '0) t_in = t_ff + TermW'(1);
      if (state_ff == ST_REP_OUT && rsp_ready) t_in = t_ff + TermW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         t_ff <= '0;
         ld_pend_ff <= 1'b0;
         score_ff <= '0;
         for (int i = 0; i < NumTerms; i++) begin
            len_ff[i] <= '0; wt_ff[i] <= '0; since_ff[i] <= '0; cnt_ff[i] <= '0;
         end
         for (int i = 0; i < MaxTermLen; i++) recent_ff[i] <= '0;
      end else begin
         state_ff <= state_in;
         t_ff <= t_in;
         ld_pend_ff <= accept && req_mode == MODE_LOAD_CHAR;
         if (accept) begin
            ld_term_ff <= req_term_index;
            ld_pos_ff <= req_char_pos;
            ld_byte_ff <= req_byte_value;
            case (req_mode)
               MODE_SET_TERM: begin
                  len_ff[req_term_index] <= (req_term_length > LenW'(MaxTermLen))
                                            ? LenW'(MaxTermLen) : req_term_length;
                  wt_ff[req_term_index] <= req_point_value;
               end
               MODE_SCAN: begin
                  for (int i = MaxTermLen-1; i > 0; i--) recent_ff[i] <= recent_ff[i-1];
                  recent_ff[0] <= folded;
               end
               MODE_EOL: begin
                  for (int i = 0; i < NumTerms; i++) since_ff[i] <= '0;
                  for (int i = 0; i < MaxTermLen; i++) recent_ff[i] <= '0;
               end
               default: ;
            endcase
         end
         if (state_ff == ST_SCAN_CMP) begin
            if (match) begin
               since_ff[t_ff] <= '0;
               if (cnt_ff[t_ff] != CountMax) cnt_ff[t_ff] <= cnt_ff[t_ff] + CountW'(1);
               score_ff <= score_add[ScoreW] ? ScoreMax : score_add[ScoreW-1:0];
            end else begin
               since_ff[t_ff] <= since_inc;
            end
         end
         if (state_ff == ST_REP_MUL)
            pts_ff <= PointsW'(cnt_ff[t_ff]) * PointsW'(wt_ff[t_ff]);
         if (state_ff == ST_REP_OUT && rsp_ready) cnt_ff[t_ff] <= '0;
         if (state_ff == ST_TOT_OUT && rsp_ready) score_ff <= '0;
      end
   end

   always_comb begin
      rsp_valid = (state_ff == ST_REP_OUT) || (state_ff == ST_TOT_OUT);
      rsp_is_total = (state_ff == ST_TOT_OUT);
      rsp_last = rsp_is_total;
      rsp_out_term = rsp_is_total ? '0 : t_ff;
      rsp_hit_count = rsp_is_total ? '0 : cnt_ff[t_ff];
      rsp_term_points = rsp_is_total ? '0 : pts_ff;
      rsp_total_score = rsp_is_total ? score_ff : '0;
   end
endmodule

### rtl/wks_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module wks_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_data <= mem_ff[rd_addr];
   end
endmodule

### tb/tb.sv
// Self-checking bench for weighted_keyword_scan: loads terms, scans text and checks report items.
// Depends on wks_pkg and the weighted_keyword_scan RTL.
module tb;
   import wks_pkg::*;

   localparam logic [2:0] MODE_SPARE_FIRST = 3'd5;
   localparam logic [2:0] MODE_SPARE_LAST  = 3'd7;

   typedef struct packed {
      logic [2:0]         mode;
      logic [TermW-1:0]   idx;
      logic [PosW-1:0]    pos;
      logic [7:0]         byt;
      logic [LenW-1:0]    len;
      logic [3:0]         wt;
   } scan_req_type;

   typedef struct packed {
      logic [TermW-1:0]   term;
      logic [CountW-1:0]  cnt;
      logic [PointsW-1:0] pts;
      logic [ScoreW-1:0]  tot;
      logic               is_tot;
      logic               lst;
   } report_line_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [2:0] req_mode = '0;
   logic [TermW-1:0] req_term_index = '0;
   logic [PosW-1:0] req_char_pos = '0;
   logic [7:0] req_byte_value = '0;
   logic [LenW-1:0] req_term_length = '0;
   logic [3:0] req_point_value = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [TermW-1:0] rsp_out_term;
   logic [CountW-1:0] rsp_hit_count;
   logic [PointsW-1:0] rsp_term_points;
   logic [ScoreW-1:0] rsp_total_score;
   logic rsp_is_total;
   logic rsp_last;

   weighted_keyword_scan dut (.*);

   always #1 clock = ~clock;

   initial begin
      #2000000;
      $display("Simulation FAILED");
      $finish;
   end

   // predictor state
   logic [7:0]        kw_chars [NumTerms][MaxTermLen];
   logic [LenW-1:0]   kw_len [NumTerms];
   logic [3:0]        kw_wt [NumTerms];
   logic [7:0]        window [MaxTermLen];
   logic [LenW-1:0]   since_hit [NumTerms];
   logic [CountW-1:0] hits [NumTerms];
   logic [ScoreW-1:0] score;

   scan_req_type    pending [$];
   report_line_type report_q [$];
   int errors = 0;
   int req_count = 0;
   int rsp_count = 0;

   task automatic push_line(input int t, input int c, input int p, input int s, input bit tot);
      report_line_type l;
      l.term = TermW'(t); l.cnt = CountW'(c); l.pts = PointsW'(p); l.tot = ScoreW'(s);
      l.is_tot = tot; l.lst = tot;
      report_q = {report_q, l};
   endtask

   task automatic predict_item(input scan_req_type it);
      logic [7:0] b;
      bit ok;
      case (it.mode)
         MODE_LOAD_CHAR: kw_chars[it.idx][it.pos] = it.byt;
         MODE_SET_TERM: begin
            kw_len[it.idx] = (it.len > MaxTermLen) ? LenW'(MaxTermLen) : it.len;
            kw_wt[it.idx] = it.wt;
         end
         MODE_SCAN: begin
            b = (it.byt >= "A" && it.byt <= "Z") ? it.byt + 8'd32 : it.byt;
            for (int i = MaxTermLen - 1; i > 0; i--) window[i] = window[i-1];
            window[0] = b;
            for (int t = 0; t < NumTerms; t++) begin
               if (since_hit[t] < MaxTermLen) since_hit[t]++;
               ok = kw_len[t] != 0 && since_hit[t] >= kw_len[t];
               for (int p = 0; p < MaxTermLen; p++)
                  if (ok && p < kw_len[t] && kw_chars[t][p] != window[kw_len[t]-1-p])
                     ok = 1'b0;
               if (ok) begin
                  since_hit[t] = '0;
                  if (hits[t] != CountMax) hits[t]++;
                  score = (25'(score) + kw_wt[t] > 25'(ScoreMax)) ? ScoreMax
                        : score + kw_wt[t];
               end
            end
         end
         MODE_EOL: begin
            foreach (since_hit[t]) since_hit[t] = '0;
            foreach (window[i]) window[i] = '0;
         end
         MODE_REPORT: begin
            for (int t = 0; t < NumTerms; t++)
               if (hits[t] != 0) push_line(t, hits[t], hits[t] * kw_wt[t], 0, 0);
            push_line(0, 0, 0, score, 1);
            foreach (hits[t]) hits[t] = '0;
            score = '0;
         end
         default: ;
      endcase
   endtask

   task automatic add_item(input logic [2:0] m, input int t, input int p, input int b,
                           input int l, input int w);
      scan_req_type it;
      it.mode = m; it.idx = TermW'(t); it.pos = PosW'(p); it.byt = 8'(b);
      it.len = LenW'(l); it.wt = 4'(w);
      pending = {pending, it};
   endtask

   // load chars for the used positions then enable; wild mixes in arbitrary bytes
   task automatic define_term(input int t, input int l, input int w, input string txt,
                              input bit wild);
      int n;
      n = (l > MaxTermLen) ? MaxTermLen : l;
      for (int p = 0; p < n; p++)
         add_item(MODE_LOAD_CHAR, t, p,
                  (wild && $urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                  : (p < txt.len()) ? txt[p] : "a", 0, 0);
      add_item(MODE_SET_TERM, t, 0, 0, l, w);
   endtask

   task automatic scan_text(input string s);
      foreach (s[i]) add_item(MODE_SCAN, 0, 0, s[i], 0, 0);
   endtask

   function automatic int text_byte();
      int r;
      r = $urandom_range(0, 9);
      if (r < 6) return "a" + $urandom_range(0, 2);
      if (r < 8) return "A" + $urandom_range(0, 2);
      return $urandom_range(0, 255);
   endfunction

   // driver
   bit req_took = 0;
   int req_gap = 0;
   always @(posedge clock) begin
      req_took <= 0;
      if (!reset && req_valid && req_ready) begin
         predict_item({req_mode, req_term_index, req_char_pos, req_byte_value,
                       req_term_length, req_point_value});
         req_count++;
         req_took <= 1;
      end
   end

   always @(negedge clock) begin
      scan_req_type it;
      if (!reset && (!req_valid || req_took)) begin
         if (req_took) req_gap = ((req_count / 60) % 3 == 1) ? 0 : $urandom_range(0, 3);
         if (req_gap == 0 && pending.size() > 0) begin
            it = pending.pop_front();
            {req_mode, req_term_index, req_char_pos, req_byte_value,
             req_term_length, req_point_value} <= it;
            req_valid <= 1;
         end else begin
            req_valid <= 0;
            if (req_gap > 0) req_gap--;
         end
      end
   end

   // monitor and receiver
   bit rsp_took = 0;
   bit long_done = 0;
   int rsp_hold = 0;
   always @(posedge clock) begin
      report_line_type want;
      rsp_took <= 0;
      if (!reset && rsp_valid && rsp_ready) begin
         rsp_took <= 1;
         rsp_count++;
         if (report_q.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected report item term=%0d", rsp_out_term);
         end else begin
            want = report_q.pop_front();
            if (want.term !== rsp_out_term || want.cnt !== rsp_hit_count ||
                want.pts !== rsp_term_points || want.tot !== rsp_total_score ||
                want.is_tot !== rsp_is_total || want.lst !== rsp_last) begin
               errors++;
               if (errors <= 10)
                  $display("mismatch exp term=%0d cnt=%0d pts=%0d tot=%0d is_tot=%b last=%b",
                           want.term, want.cnt, want.pts, want.tot, want.is_tot, want.lst,
                           " got term=%0d cnt=%0d pts=%0d tot=%0d is_tot=%b last=%b",
                           rsp_out_term, rsp_hit_count, rsp_term_points, rsp_total_score,
                           rsp_is_total, rsp_last);
            end
         end
      end
   end

   always @(negedge clock) begin
      if (!reset) begin
         if (rsp_took) begin
            if (!long_done && rsp_count >= 20) begin
               rsp_hold = 400;
               long_done = 1;
            end else begin
               rsp_hold = ((rsp_count / 40) % 3 == 2) ? 0 : $urandom_range(0, 3);
            end
         end else if (rsp_hold > 0) begin
            rsp_hold--;
         end
         rsp_ready <= (rsp_hold == 0);
      end
   end

   initial begin
      int r, t;
      foreach (kw_len[i]) begin
         kw_len[i] = '0; kw_wt[i] = '0; since_hit[i] = '0; hits[i] = '0;
      end
      foreach (window[i]) window[i] = '0;
      score = '0;

      // directed: empty report, extremes, overlong, disable, mid-line load, spare modes
      add_item(MODE_REPORT, 0, 0, 0, 0, 0);
      define_term(0, 2, 15, "ab", 0);
      define_term(31, 3, 1, "aaa", 0);
      add_item(MODE_LOAD_CHAR, 7, 15, 8'hFF, 0, 0);
      scan_text("ABabaaaa");
      define_term(5, 31, 9, "bbbbbbbbbbbbbbbb", 0);
      scan_text("aAa");
      add_item(MODE_EOL, 0, 0, 0, 0, 0);
      add_item(MODE_SPARE_FIRST, 31, 15, 255, 31, 15);
      add_item(MODE_SPARE_LAST, 0, 0, 0, 0, 0);
      add_item(MODE_SET_TERM, 31, 0, 0, 0, 0);
      add_item(MODE_SCAN, 0, 0, 8'h00, 0, 0);
      add_item(MODE_REPORT, 0, 0, 0, 0, 0);

      define_term(6, 16, 7, "abcabcabcabcabca", 0);
      for (int i = 0; i < 8; i++) define_term($urandom_range(0, 31),
                                              $urandom_range(1, 3), $urandom_range(0, 15),
                                              "abc", 0);
      while (pending.size() < 350) begin
         r = $urandom_range(0, 99);
         t = $urandom_range(0, NumTerms - 1);
         if (r < 62) add_item(MODE_SCAN, 0, 0, text_byte(), 0, 0);
         else if (r < 70) add_item(MODE_EOL, 0, 0, 0, 0, 0);
         else if (r < 75) add_item(MODE_REPORT, 0, 0, 0, 0, 0);
         else if (r < 85) begin
            // short terms hit often; rarely a full-size or disabled one
            case ($urandom_range(0, 9))
               0: define_term(t, $urandom_range(16, 31), $urandom_range(0, 15), "aaaa", 1);
               1: define_term(t, 0, $urandom_range(0, 15), "", 0);
               default: define_term(t, $urandom_range(1, 4), $urandom_range(0, 15),
                                    $urandom_range(0, 1) ? "abca" : "cbaa", $urandom_range(0, 1));
            endcase
         end else if (r < 96) add_item(MODE_LOAD_CHAR, t, $urandom_range(0, 15),
                                       $urandom_range(0, 1) ? text_byte() + 0 : $urandom_range(0, 255),
                                       0, 0);
         else add_item(3'($urandom_range(MODE_SPARE_FIRST, MODE_SPARE_LAST)),
                       t, $urandom_range(0, 15), $urandom_range(0, 255),
                       $urandom_range(0, 31), $urandom_range(0, 15));
      end
      add_item(MODE_REPORT, 0, 0, 0, 0, 0);

      repeat (9) @(posedge clock);
      @(negedge clock) reset = 0;

      while (pending.size() > 0 || req_valid || report_q.size() > 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (errors == 0 && report_q.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end
endmodule
